// File: sv/z80io_pkg.sv
`timescale 1ns / 1ps

package z80io_pkg;

  typedef logic [1:0] acc_t;
  typedef logic [2:0] reg_code_t;

  // first instruction bytes
  localparam logic [7:0] OP_IN_N      = 8'hDB;
  localparam logic [7:0] OP_OUT_N     = 8'hD3;
  localparam logic [7:0] OP_PREFIX_ED = 8'hED;

  // ED sub-opcode decode
  localparam logic [7:0] SUB_RC_MASK   = 8'hC7;
  localparam logic [7:0] SUB_IN_RC     = 8'h40;
  localparam logic [7:0] SUB_OUT_RC    = 8'h41;
  localparam logic [7:0] SUB_BLK_MASK  = 8'hE6;
  localparam logic [7:0] SUB_BLK_MATCH = 8'hA2;
  localparam int unsigned SUB_BIT_OUT  = 0;
  localparam int unsigned SUB_BIT_DEC  = 3;
  localparam int unsigned SUB_BIT_REP  = 4;

  // access kinds
  localparam acc_t ACC_NONE = 2'd0;
  localparam acc_t ACC_PORT = 2'd1;
  localparam acc_t ACC_MEM  = 2'd2;

  // register codes
  localparam reg_code_t R_B      = 3'd0;
  localparam reg_code_t R_C      = 3'd1;
  localparam reg_code_t R_D      = 3'd2;
  localparam reg_code_t R_E      = 3'd3;
  localparam reg_code_t R_H      = 3'd4;
  localparam reg_code_t R_L      = 3'd5;
  localparam reg_code_t R_UNUSED = 3'd6;
  localparam reg_code_t R_A      = 3'd7;

  // flag bit positions
  localparam int unsigned F_S  = 7;
  localparam int unsigned F_Z  = 6;
  localparam int unsigned F_H  = 4;
  localparam int unsigned F_PV = 2;
  localparam int unsigned F_N  = 1;

  // T-state counts
  localparam logic [4:0] CYC_NONE    = 5'd0;
  localparam logic [4:0] CYC_IMM     = 5'd11;
  localparam logic [4:0] CYC_RC      = 5'd12;
  localparam logic [4:0] CYC_BLK     = 5'd16;
  localparam logic [4:0] CYC_BLK_REP = 5'd21;

endpackage

// File: sv/z80_io_instruction_unit.sv
`timescale 1ns / 1ps

// Z80 I/O instruction unit. Each input item is one instruction (IN A,(n), OUT (n),A,
// IN r,(C), OUT (C),r, INI/IND/OUTI/OUTD and their repeating forms) together with the
// byte its port or memory read returned; each item yields exactly one result item
// describing the accesses, write data, new flags, next PC and T-state count.
// Throughput is one item per clock while the result side keeps taking results: an item
// sits in the input register, the decode, register-file update, parity and flag logic
// settle combinationally, and the result register and the architectural state (B..L, A,
// F, PC) load on the same edge, so the next item already sees the updated state.
// out_valid rises once the item has moved from the input register into the result
// register. The input register keeps accepting while a result waits to be taken;
// backpressure reaches in_ready only when both registers hold an item and out_ready
// is low.
// Unknown opcodes leave the state untouched and report recognized = 0, cycles = 0.

module z80_io_instruction_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_second_byte,
  input  logic [7:0]  in_read_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_recognized,
  output logic [1:0]  out_read_source,
  output logic [1:0]  out_write_target,
  output logic [7:0]  out_port_address,
  output logic [15:0] out_mem_address,
  output logic [7:0]  out_write_data,
  output logic [7:0]  out_flag_bits,
  output logic [15:0] out_next_pc,
  output logic [4:0]  out_cycles,
  output logic        out_repeating
);

  // input register
  logic       in_valid_r;
  logic [7:0] op_r, sb_r, rv_r;

  // architectural state
  logic [7:0]  regs_r [8];
  logic [7:0]  regs_nxt [8];
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] pc_r, pc_nxt;

  // result register
  logic        out_valid_r;
  logic        ok_r, ok_nxt;
  z80io_pkg::acc_t rsrc_r, rsrc_nxt, wtgt_r, wtgt_nxt;
  logic [7:0]  port_r, port_nxt;
  logic [15:0] mem_r, mem_nxt;
  logic [7:0]  wdata_r, wdata_nxt;
  logic [4:0]  cyc_r, cyc_nxt;
  logic        rep_r, rep_nxt;

  logic out_free, advance;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  // decode
  z80io_pkg::reg_code_t r_sel;
  logic        is_in_rc, is_out_rc, is_blk;
  logic        blk_out, blk_dec, blk_rep;
  logic [15:0] hl, hl_upd, pc_step;
  logic [7:0]  b_dec;

  assign r_sel   = sb_r[5:3];
  assign is_in_rc  = (op_r == z80io_pkg::OP_PREFIX_ED)
                  && ((sb_r & z80io_pkg::SUB_RC_MASK) == z80io_pkg::SUB_IN_RC)
                  && (r_sel != z80io_pkg::R_UNUSED);
  assign is_out_rc = (op_r == z80io_pkg::OP_PREFIX_ED)
                  && ((sb_r & z80io_pkg::SUB_RC_MASK) == z80io_pkg::SUB_OUT_RC)
                  && (r_sel != z80io_pkg::R_UNUSED);
  assign is_blk    = (op_r == z80io_pkg::OP_PREFIX_ED)
                  && ((sb_r & z80io_pkg::SUB_BLK_MASK) == z80io_pkg::SUB_BLK_MATCH);
  assign blk_out = sb_r[z80io_pkg::SUB_BIT_OUT];
  assign blk_dec = sb_r[z80io_pkg::SUB_BIT_DEC];
  assign blk_rep = sb_r[z80io_pkg::SUB_BIT_REP];

  assign hl      = {regs_r[z80io_pkg::R_H], regs_r[z80io_pkg::R_L]};
  assign hl_upd  = blk_dec ? (hl - 16'd1) : (hl + 16'd1);
  assign b_dec   = regs_r[z80io_pkg::R_B] - 8'd1;
  assign pc_step = pc_r + 16'd2;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      regs_nxt[i] = regs_r[i];
    end
    flags_nxt = flags_r;
    pc_nxt    = pc_r;
    ok_nxt    = 1'b0;
    rsrc_nxt  = z80io_pkg::ACC_NONE;
    wtgt_nxt  = z80io_pkg::ACC_NONE;
    port_nxt  = 8'd0;
    mem_nxt   = 16'd0;
    wdata_nxt = 8'd0;
    cyc_nxt   = z80io_pkg::CYC_NONE;
    rep_nxt   = 1'b0;

    if (op_r == z80io_pkg::OP_IN_N) begin
      ok_nxt   = 1'b1;
      rsrc_nxt = z80io_pkg::ACC_PORT;
      port_nxt = sb_r;
      regs_nxt[z80io_pkg::R_A] = rv_r;
      pc_nxt   = pc_step;
      cyc_nxt  = z80io_pkg::CYC_IMM;
    end else if (op_r == z80io_pkg::OP_OUT_N) begin
      ok_nxt    = 1'b1;
      wtgt_nxt  = z80io_pkg::ACC_PORT;
      port_nxt  = sb_r;
      wdata_nxt = regs_r[z80io_pkg::R_A];
      pc_nxt    = pc_step;
      cyc_nxt   = z80io_pkg::CYC_IMM;
    end else if (is_in_rc) begin
      ok_nxt   = 1'b1;
      rsrc_nxt = z80io_pkg::ACC_PORT;
      port_nxt = regs_r[z80io_pkg::R_C];
      regs_nxt[r_sel] = rv_r;
      flags_nxt[z80io_pkg::F_S]  = rv_r[7];
      flags_nxt[z80io_pkg::F_Z]  = (rv_r == 8'd0);
      flags_nxt[z80io_pkg::F_H]  = 1'b0;
      flags_nxt[z80io_pkg::F_PV] = ~^rv_r;   // even parity
      flags_nxt[z80io_pkg::F_N]  = 1'b0;
      pc_nxt   = pc_step;
      cyc_nxt  = z80io_pkg::CYC_RC;
    end else if (is_out_rc) begin
      ok_nxt    = 1'b1;
      wtgt_nxt  = z80io_pkg::ACC_PORT;
      port_nxt  = regs_r[z80io_pkg::R_C];
      wdata_nxt = regs_r[r_sel];
      pc_nxt    = pc_step;
      cyc_nxt   = z80io_pkg::CYC_RC;
    end else if (is_blk) begin
      ok_nxt    = 1'b1;
      port_nxt  = regs_r[z80io_pkg::R_C];
      mem_nxt   = hl;
      wdata_nxt = rv_r;
      rsrc_nxt  = blk_out ? z80io_pkg::ACC_MEM  : z80io_pkg::ACC_PORT;
      wtgt_nxt  = blk_out ? z80io_pkg::ACC_PORT : z80io_pkg::ACC_MEM;
      regs_nxt[z80io_pkg::R_B] = b_dec;
      regs_nxt[z80io_pkg::R_H] = hl_upd[15:8];
      regs_nxt[z80io_pkg::R_L] = hl_upd[7:0];
      flags_nxt[z80io_pkg::F_N] = 1'b1;
      if (blk_rep) begin
        flags_nxt[z80io_pkg::F_Z] = 1'b1;
        if (b_dec != 8'd0) begin
          rep_nxt = 1'b1;
          cyc_nxt = z80io_pkg::CYC_BLK_REP;
        end else begin
          pc_nxt  = pc_step;
          cyc_nxt = z80io_pkg::CYC_BLK;
        end
      end else begin
        flags_nxt[z80io_pkg::F_Z] = (b_dec == 8'd0);
        pc_nxt  = pc_step;
        cyc_nxt = z80io_pkg::CYC_BLK;
      end
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= 8'd0;
      pc_r        <= 16'd0;
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= 8'd0;
      end
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
        pc_r        <= pc_nxt;
        for (int i = 0; i < 8; i++) begin
          regs_r[i] <= regs_nxt[i];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_opcode;
      sb_r <= in_second_byte;
      rv_r <= in_read_value;
    end
    if (advance) begin
      ok_r    <= ok_nxt;
      rsrc_r  <= rsrc_nxt;
      wtgt_r  <= wtgt_nxt;
      port_r  <= port_nxt;
      mem_r   <= mem_nxt;
      wdata_r <= wdata_nxt;
      cyc_r   <= cyc_nxt;
      rep_r   <= rep_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_recognized   = ok_r;
  assign out_read_source  = rsrc_r;
  assign out_write_target = wtgt_r;
  assign out_port_address = port_r;
  assign out_mem_address  = mem_r;
  assign out_write_data   = wdata_r;
  assign out_flag_bits    = flags_r;   // state register doubles as the reported value
  assign out_next_pc      = pc_r;
  assign out_cycles       = cyc_r;
  assign out_repeating    = rep_r;

endmodule

// File: sv/z80io_checker.sv
`timescale 1ns / 1ps

module z80io_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_recognized,
  input logic [1:0]  out_read_source,
  input logic [1:0]  out_write_target,
  input logic [4:0]  out_cycles,
  input logic        out_repeating,
  input logic [15:0] out_next_pc
);

  // nothing valid right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // unknown instruction reports no access and zero T-states
  a_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_recognized) |->
      (out_read_source == z80io_pkg::ACC_NONE && out_write_target == z80io_pkg::ACC_NONE
       && out_cycles == z80io_pkg::CYC_NONE && !out_repeating))
    else $error("unknown instruction reported activity");

  // repeating result carries the CYC_BLK_REP T-state count and both accesses
  a_repeat_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_repeating) |->
      (out_recognized && out_cycles == z80io_pkg::CYC_BLK_REP
       && out_read_source != z80io_pkg::ACC_NONE
       && out_write_target != z80io_pkg::ACC_NONE))
    else $error("repeating result inconsistent");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_next_pc) && $stable(out_cycles)))
    else $error("stalled result changed");

  // input side only stalls behind a result that is waiting
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low with no result waiting");

endmodule

bind z80_io_instruction_unit z80io_checker u_z80io_checker (.*);

// File: dv/z80io_result_checker.sv
`timescale 1ns / 1ps

module z80io_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_second_byte,
  input  logic [7:0]  in_read_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_recognized,
  input  logic [1:0]  out_read_source,
  input  logic [1:0]  out_write_target,
  input  logic [7:0]  out_port_address,
  input  logic [15:0] out_mem_address,
  input  logic [7:0]  out_write_data,
  input  logic [7:0]  out_flag_bits,
  input  logic [15:0] out_next_pc,
  input  logic [4:0]  out_cycles,
  input  logic        out_repeating,
  output int          fail_count,
  output int          results_pending,
  output int          results_checked
);

  typedef struct packed {
    logic            recognized;
    z80io_pkg::acc_t read_source;
    z80io_pkg::acc_t write_target;
    logic [7:0]      port_address;
    logic [15:0]     mem_address;
    logic [7:0]      write_data;
    logic [7:0]      flag_bits;
    logic [15:0]     next_pc;
    logic [4:0]      cycles;
    logic            repeating;
  } io_result_t;

  // shadow CPU state
  logic [7:0]  regs [8];
  logic [7:0]  flags;
  logic [15:0] pc;

  io_result_t io_results_due [$];

  task automatic exec_io_instruction(input logic [7:0] op, input logic [7:0] sb,
                                     input logic [7:0] rv, output io_result_t res);
    z80io_pkg::reg_code_t r;
    logic [15:0] hl;
    logic [7:0]  b;
    logic [7:0]  f;
    logic [15:0] npc;
    r   = z80io_pkg::reg_code_t'(sb[5:3]);
    f   = flags;
    npc = pc;
    res = '0;
    if (op == z80io_pkg::OP_IN_N) begin
      res.recognized   = 1'b1;
      res.read_source  = z80io_pkg::ACC_PORT;
      res.port_address = sb;
      regs[z80io_pkg::R_A] = rv;
      npc              = pc + 16'd2;
      res.cycles       = z80io_pkg::CYC_IMM;
    end else if (op == z80io_pkg::OP_OUT_N) begin
      res.recognized   = 1'b1;
      res.write_target = z80io_pkg::ACC_PORT;
      res.port_address = sb;
      res.write_data   = regs[z80io_pkg::R_A];
      npc              = pc + 16'd2;
      res.cycles       = z80io_pkg::CYC_IMM;
    end else if (op == z80io_pkg::OP_PREFIX_ED) begin
      if ((sb & z80io_pkg::SUB_RC_MASK) == z80io_pkg::SUB_IN_RC
          && r != z80io_pkg::R_UNUSED) begin
        res.recognized   = 1'b1;
        res.read_source  = z80io_pkg::ACC_PORT;
        res.port_address = regs[z80io_pkg::R_C];
        regs[r]          = rv;
        f[z80io_pkg::F_S]  = rv[7];
        f[z80io_pkg::F_Z]  = (rv == 8'h00);
        f[z80io_pkg::F_H]  = 1'b0;
        f[z80io_pkg::F_PV] = ~^rv;
        f[z80io_pkg::F_N]  = 1'b0;
        npc              = pc + 16'd2;
        res.cycles       = z80io_pkg::CYC_RC;
      end else if ((sb & z80io_pkg::SUB_RC_MASK) == z80io_pkg::SUB_OUT_RC
                   && r != z80io_pkg::R_UNUSED) begin
        res.recognized   = 1'b1;
        res.write_target = z80io_pkg::ACC_PORT;
        res.port_address = regs[z80io_pkg::R_C];
        res.write_data   = regs[r];
        npc              = pc + 16'd2;
        res.cycles       = z80io_pkg::CYC_RC;
      end else if ((sb & z80io_pkg::SUB_BLK_MASK) == z80io_pkg::SUB_BLK_MATCH) begin
        hl               = {regs[z80io_pkg::R_H], regs[z80io_pkg::R_L]};
        res.recognized   = 1'b1;
        res.port_address = regs[z80io_pkg::R_C];
        res.mem_address  = hl;
        res.write_data   = rv;
        res.read_source  = sb[z80io_pkg::SUB_BIT_OUT] ? z80io_pkg::ACC_MEM
                                                      : z80io_pkg::ACC_PORT;
        res.write_target = sb[z80io_pkg::SUB_BIT_OUT] ? z80io_pkg::ACC_PORT
                                                      : z80io_pkg::ACC_MEM;
        b                = regs[z80io_pkg::R_B] - 8'd1;
        regs[z80io_pkg::R_B] = b;
        hl               = sb[z80io_pkg::SUB_BIT_DEC] ? hl - 16'd1 : hl + 16'd1;
        regs[z80io_pkg::R_H] = hl[15:8];
        regs[z80io_pkg::R_L] = hl[7:0];
        f[z80io_pkg::F_N] = 1'b1;
        if (sb[z80io_pkg::SUB_BIT_REP]) begin
          f[z80io_pkg::F_Z] = 1'b1;
          if (b != 8'h00) begin
            res.repeating = 1'b1;
            res.cycles    = z80io_pkg::CYC_BLK_REP;
          end else begin
            npc        = pc + 16'd2;
            res.cycles = z80io_pkg::CYC_BLK;
          end
        end else begin
          f[z80io_pkg::F_Z] = (b == 8'h00);
          npc        = pc + 16'd2;
          res.cycles = z80io_pkg::CYC_BLK;
        end
      end
    end
    flags         = f;
    pc            = npc;
    res.flag_bits = f;
    res.next_pc   = npc;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    io_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) regs[k] = 8'h00;
      flags = 8'h00;
      pc    = 16'h0000;
      io_results_due.delete();
    end else begin
      // retire first: a result this edge can never belong to an item taken this edge
      if (out_valid && out_ready) begin
        if (io_results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result item arrived with none expected", $time);
        end else begin
          want = io_results_due.pop_front();
          results_checked++;
          check_field("recognized",   16'(want.recognized),   16'(out_recognized));
          check_field("read_source",  16'(want.read_source),  16'(out_read_source));
          check_field("write_target", 16'(want.write_target), 16'(out_write_target));
          check_field("port_address", 16'(want.port_address), 16'(out_port_address));
          check_field("mem_address",  want.mem_address,       out_mem_address);
          check_field("write_data",   16'(want.write_data),   16'(out_write_data));
          check_field("flag_bits",    16'(want.flag_bits),    16'(out_flag_bits));
          check_field("next_pc",      want.next_pc,           out_next_pc);
          check_field("cycles",       16'(want.cycles),       16'(out_cycles));
          check_field("repeating",    16'(want.repeating),    16'(out_repeating));
        end
      end
      if (in_valid && in_ready) begin
        exec_io_instruction(in_opcode, in_second_byte, in_read_value, want);
        io_results_due.push_back(want);
      end
    end
    results_pending = io_results_due.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Top: clock, reset, instruction stream and result-side backpressure.
// All checking lives in z80io_result_checker; this module only drives and
// renders the verdict from the checker's counts.
module testbench;

  // Watchdog limit, sized well above the slowest phases over ~1000 items.
  localparam int CYCLE_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_opcode;
  logic [7:0]  in_second_byte;
  logic [7:0]  in_read_value;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_recognized;
  logic [1:0]  out_read_source;
  logic [1:0]  out_write_target;
  logic [7:0]  out_port_address;
  logic [15:0] out_mem_address;
  logic [7:0]  out_write_data;
  logic [7:0]  out_flag_bits;
  logic [15:0] out_next_pc;
  logic [4:0]  out_cycles;
  logic        out_repeating;

  // percent of cycles each side sits idle
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int cycle_count;
  int fail_count;
  int results_pending;
  int results_checked;

  always #5 clk = ~clk;

  z80_io_instruction_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_second_byte   (in_second_byte),
    .in_read_value    (in_read_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_recognized   (out_recognized),
    .out_read_source  (out_read_source),
    .out_write_target (out_write_target),
    .out_port_address (out_port_address),
    .out_mem_address  (out_mem_address),
    .out_write_data   (out_write_data),
    .out_flag_bits    (out_flag_bits),
    .out_next_pc      (out_next_pc),
    .out_cycles       (out_cycles),
    .out_repeating    (out_repeating)
  );

  z80io_result_checker io_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_second_byte   (in_second_byte),
    .in_read_value    (in_read_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_recognized   (out_recognized),
    .out_read_source  (out_read_source),
    .out_write_target (out_write_target),
    .out_port_address (out_port_address),
    .out_mem_address  (out_mem_address),
    .out_write_data   (out_write_data),
    .out_flag_bits    (out_flag_bits),
    .out_next_pc      (out_next_pc),
    .out_cycles       (out_cycles),
    .out_repeating    (out_repeating),
    .fail_count       (fail_count),
    .results_pending  (results_pending),
    .results_checked  (results_checked)
  );

  // Result side: ready toggles at random on each falling edge; held low in reset.
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("z80_io_instruction_unit: mismatch");
      $finish;
    end
  end

  // ED sub-opcode for IN r,(C) / OUT (C),r
  function automatic logic [7:0] rc_sub(input z80io_pkg::reg_code_t r,
                                        input logic out_form);
    return (out_form ? z80io_pkg::SUB_OUT_RC : z80io_pkg::SUB_IN_RC)
           | {2'b00, r, 3'b000};
  endfunction

  // ED sub-opcode for the block forms: out / decrement / repeat select bits
  function automatic logic [7:0] blk_sub(input logic out_form, input logic dec,
                                         input logic rep);
    logic [7:0] s;
    s                        = z80io_pkg::SUB_BLK_MATCH;
    s[z80io_pkg::SUB_BIT_OUT] = out_form;
    s[z80io_pkg::SUB_BIT_DEC] = dec;
    s[z80io_pkg::SUB_BIT_REP] = rep;
    return s;
  endfunction

  // Present one item, possibly after some idle cycles, and hold it until taken.
  // Called and returns at a falling edge; valid stays high across back-to-back
  // items, so it only drops when the sender actually idles.
  task automatic send_item(input logic [7:0] op, input logic [7:0] sb,
                           input logic [7:0] rv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_second_byte <= sb;
    in_read_value  <= rv;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Stop sending and wait until the checker has seen every predicted result.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  // Random instruction stream. About a third is a well-formed block transfer:
  // load H, L and B (small count), then issue one block form B times so repeat
  // forms run their loop out to B = 0. The rest is single I/O instructions,
  // including the unused register code, plus noise opcodes / sub-opcodes.
  task automatic random_mix(input int count);
    int         stop;
    int         pick;
    int         reps;
    logic [7:0] form;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // bias HL toward the wrap points
        send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_H, 1'b0),
                  ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255)));
        send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_L, 1'b0),
                  ($urandom_range(3) == 0) ? 8'hFE : 8'($urandom_range(255)));
        reps = $urandom_range(1, 6);
        send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_B, 1'b0), 8'(reps));
        form = blk_sub(1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
        repeat (reps) send_item(z80io_pkg::OP_PREFIX_ED, form, 8'($urandom_range(255)));
      end else if (pick < 55) begin
        send_item($urandom_range(1) ? z80io_pkg::OP_IN_N : z80io_pkg::OP_OUT_N,
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (pick < 85) begin
        send_item(z80io_pkg::OP_PREFIX_ED,
                  rc_sub(z80io_pkg::reg_code_t'($urandom_range(7)),
                         1'($urandom_range(1))), 8'($urandom_range(255)));
      end else if (pick < 93) begin
        send_item(z80io_pkg::OP_PREFIX_ED, 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end else begin
        send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = 8'h00;
    in_second_byte = 8'h00;
    in_read_value  = 8'h00;
    send_idle_pct  = 36;
    recv_idle_pct  = 72;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed: every form, field extremes, wraps and unknown encodings ----
    send_item(z80io_pkg::OP_IN_N,  8'hFF, 8'hFF);                         // IN A,(FF)
    send_item(z80io_pkg::OP_OUT_N, 8'h00, 8'h00);                         // OUT (00),A
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_B, 1'b0), 8'h02); // B = 2
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_C, 1'b0), 8'h80); // sign set
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_D, 1'b0), 8'h00); // zero flag
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_E, 1'b0), 8'hFF);
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_H, 1'b0), 8'hFF);
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_L, 1'b0), 8'hFF); // HL = FFFF
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_A, 1'b0), 8'h7F);
    // unused register code, both directions: not handled
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_UNUSED, 1'b0), 8'h55);
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_UNUSED, 1'b1), 8'hAA);
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_B, 1'b1), 8'h00);
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_H, 1'b1), 8'h00);
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_A, 1'b1), 8'h00);
    send_item(z80io_pkg::OP_PREFIX_ED, blk_sub(1'b0, 1'b0, 1'b0), 8'hAA); // INI: HL up, B 1
    send_item(z80io_pkg::OP_PREFIX_ED, blk_sub(1'b0, 1'b1, 1'b0), 8'h55); // IND: HL dn, B 0
    send_item(z80io_pkg::OP_PREFIX_ED, blk_sub(1'b1, 1'b0, 1'b0), 8'h01); // OUTI: B to FF
    send_item(z80io_pkg::OP_PREFIX_ED, blk_sub(1'b0, 1'b0, 1'b1), 8'hFE); // INIR: loops
    send_item(z80io_pkg::OP_PREFIX_ED, rc_sub(z80io_pkg::R_B, 1'b0), 8'h01);
    send_item(z80io_pkg::OP_PREFIX_ED, blk_sub(1'b1, 1'b1, 1'b1), 8'h80); // OTDR: last pass
    send_item(z80io_pkg::OP_PREFIX_ED, blk_sub(1'b0, 1'b1, 1'b1), 8'h7F); // INDR from B 0
    send_item(z80io_pkg::OP_PREFIX_ED, blk_sub(1'b1, 1'b0, 1'b1), 8'h33); // OTIR
    send_item(z80io_pkg::OP_PREFIX_ED, blk_sub(1'b1, 1'b1, 1'b0), 8'hCC); // OUTD
    send_item(8'h00, 8'h00, 8'h00);                                     // unknown opcode
    send_item(z80io_pkg::OP_PREFIX_ED, 8'hA0, 8'h00);                   // block-like
    send_item(8'hFF, 8'hFF, 8'hFF);                                     // unknown, all ones

    // ---- random: sender idles lightly, receiver heavily ----
    random_mix(330);
    // hold off until the pipeline is fully empty, then resume
    wait_all_results();

    // ---- random: roles swapped ----
    send_idle_pct = 72;
    recv_idle_pct = 36;
    random_mix(330);

    // ---- random: no idling at all ----
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_mix(340);

    wait_all_results();
    repeat (8) @(posedge clk);

    $display("Ran %0d instructions, %0d results compared: immediate, register and",
             items_sent, results_checked);
    $display("block I/O forms, unknown encodings, B/HL wrap, three idle mixes.");
    if (fail_count == 0 && results_pending == 0) begin
      $display("z80_io_instruction_unit: match");
    end else begin
      $display("z80_io_instruction_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
sv/z80io_pkg.sv
sv/z80_io_instruction_unit.sv
sv/z80io_checker.sv
dv/z80io_result_checker.sv
dv/testbench.sv
